### rtl/lc3ie_pkg.sv
// shared types, constants and helpers for the lc3 execute unit
`timescale 1ns / 1ps
package lc3ie_pkg;

  // word and storage geometry
  localparam int WORD_BITS     = 16;
  localparam int MEM_ADDR_BITS = 16;
  localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
  localparam int REG_COUNT     = 8;
  localparam int REG_BITS      = 3;

  // condition code encodings
  localparam logic [2:0] CC_POS  = 3'd1;
  localparam logic [2:0] CC_ZERO = 3'd2;
  localparam logic [2:0] CC_NEG  = 3'd4;

  // link register for subroutine calls
  localparam logic [REG_BITS-1:0] LINK_REG = 3'd7;

  // item kinds on the opcode input
  localparam logic ITEM_EXEC     = 1'b0;
  localparam logic ITEM_MEM_LOAD = 1'b1;

  // executed instruction opcodes, bits 15 to 12
  typedef enum logic [3:0] {
    OP_BR  = 4'h0,
    OP_ADD = 4'h1,
    OP_LD  = 4'h2,
    OP_JSR = 4'h4,
    OP_AND = 4'h5,
    OP_NOT = 4'h9,
    OP_LDI = 4'hA,
    OP_JMP = 4'hC
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LDI
  } state_t;

  // flags from a written value
  function automatic logic [2:0] flags_of(input logic [WORD_BITS-1:0] v);
    logic [2:0] f;
    if (v == '0) begin
      f = CC_ZERO;
    end else if (v[WORD_BITS-1]) begin
      f = CC_NEG;
    end else begin
      f = CC_POS;
    end
    return f;
  endfunction

  // pc-relative offset, 9-bit field
  function automatic logic [WORD_BITS-1:0] sext9(input logic [8:0] v);
    return {{(WORD_BITS-9){v[8]}}, v};
  endfunction

  // pc-relative offset, 11-bit field
  function automatic logic [WORD_BITS-1:0] sext11(input logic [10:0] v);
    return {{(WORD_BITS-11){v[10]}}, v};
  endfunction

  // immediate operand, 5-bit field
  function automatic logic [WORD_BITS-1:0] sext5(input logic [4:0] v);
    return {{(WORD_BITS-5){v[4]}}, v};
  endfunction

endpackage

### rtl/lc3ie_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
module lc3ie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/lc3_instruction_execute.sv
// LC-3 execute unit: an instruction or a memory-load beat per start,
// one result per beat.
//
// A beat is taken when start is high and busy is low. Every item gives
// exactly one result, shown for a single cycle with done high; the
// receiver has no way to stall it. After acceptance an item passes
// through ST_EXEC into the result registers; LDI passes through ST_EXEC
// and then ST_LDI, since its second memory read depends on the first
// one's registered data. busy covers the work cycles only, so the next
// beat can be accepted in the same cycle its predecessor's result is
// shown. Registers R0-R7 sit in two copies of an 8-entry ram (one per
// source operand) with reset valid bits, so no clearing pass is needed;
// the word memory is not cleared and a word must be written by a
// memory-load beat before LD or LDI reads it.
`timescale 1ns / 1ps
module lc3_instruction_execute (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [15:0] instruction,
  input  logic [15:0] pc,
  input  logic [15:0] mem_addr,
  input  logic [15:0] mem_data,
  output logic        done,
  output logic [15:0] next_pc,
  output logic        reg_written,
  output logic [2:0]  reg_index,
  output logic [15:0] reg_value,
  output logic [2:0]  cond_code,
  output logic        unsupported
);

  localparam int W  = lc3ie_pkg::WORD_BITS;
  localparam int AB = lc3ie_pkg::MEM_ADDR_BITS;
  localparam int RB = lc3ie_pkg::REG_BITS;

  lc3ie_pkg::state_t state, state_next;

  // captured beat
  logic         opcode_q;
  logic [W-1:0] ins_q;
  logic [W-1:0] pc_q;
  logic         va_q;
  logic         vb_q;

  logic [lc3ie_pkg::REG_COUNT-1:0] rf_valid;
  logic [2:0]                      cc;

  logic accept;
  logic fin;

  // memory ports
  logic          mem_we;
  logic [AB-1:0] mem_raddr;
  logic [W-1:0]  mem_rdata;
  logic [W-1:0]  ld_addr;

  // register file ports
  logic [RB-1:0] rfa_raddr, rfb_raddr;
  logic [W-1:0]  rfa_rdata, rfb_rdata;

  // execute results
  logic [W-1:0]  res_pc;
  logic          res_wr;
  logic [RB-1:0] res_idx;
  logic [W-1:0]  res_val;
  logic          res_unsup;
  logic          res_cc_upd;
  logic          res_ldi;

  // operands
  logic [W-1:0]  opa, opb;
  lc3ie_pkg::op_t op;

  assign accept = start && !busy;
  assign busy   = (state != lc3ie_pkg::ST_IDLE);
  assign op     = lc3ie_pkg::op_t'(ins_q[15:12]);

  // word memory: load beats write at accept, reads are address chained
  assign mem_we  = accept && (opcode == lc3ie_pkg::ITEM_MEM_LOAD);
  assign ld_addr = pc + lc3ie_pkg::sext9(instruction[8:0]);

  always_comb begin
    if (state == lc3ie_pkg::ST_IDLE) begin
      mem_raddr = ld_addr[AB-1:0];
    end else begin
      mem_raddr = mem_rdata[AB-1:0];
    end
  end

  lc3ie_ram #(.WIDTH(W), .DEPTH(lc3ie_pkg::MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr[AB-1:0]),
    .wdata (mem_data),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // register file, one copy per source operand
  assign rfa_raddr = instruction[8:6];
  assign rfb_raddr = instruction[2:0];

  lc3ie_ram #(.WIDTH(W), .DEPTH(lc3ie_pkg::REG_COUNT)) u_rfa (
    .clk   (clk),
    .we    (fin && res_wr),
    .waddr (res_idx),
    .wdata (res_val),
    .raddr (rfa_raddr),
    .rdata (rfa_rdata)
  );

  lc3ie_ram #(.WIDTH(W), .DEPTH(lc3ie_pkg::REG_COUNT)) u_rfb (
    .clk   (clk),
    .we    (fin && res_wr),
    .waddr (res_idx),
    .wdata (res_val),
    .raddr (rfb_raddr),
    .rdata (rfb_rdata)
  );

  // operand select, never-written registers read as zero
  always_comb begin
    opa = va_q ? rfa_rdata : '0;
    if (ins_q[5]) begin
      opb = lc3ie_pkg::sext5(ins_q[4:0]);
    end else begin
      opb = vb_q ? rfb_rdata : '0;
    end
  end

  // decode and execute
  always_comb begin
    res_pc     = pc_q;
    res_wr     = 1'b0;
    res_idx    = '0;
    res_val    = '0;
    res_unsup  = 1'b0;
    res_cc_upd = 1'b0;
    res_ldi    = 1'b0;
    if (state == lc3ie_pkg::ST_LDI) begin
      res_wr     = 1'b1;
      res_idx    = ins_q[11:9];
      res_val    = mem_rdata;
      res_cc_upd = 1'b1;
    end else if (opcode_q == lc3ie_pkg::ITEM_EXEC) begin
      unique case (op)
        lc3ie_pkg::OP_ADD: begin
          res_wr     = 1'b1;
          res_idx    = ins_q[11:9];
          res_val    = opa + opb;
          res_cc_upd = 1'b1;
        end
        lc3ie_pkg::OP_AND: begin
          res_wr     = 1'b1;
          res_idx    = ins_q[11:9];
          res_val    = opa & opb;
          res_cc_upd = 1'b1;
        end
        lc3ie_pkg::OP_NOT: begin
          res_wr     = 1'b1;
          res_idx    = ins_q[11:9];
          res_val    = ~opa;
          res_cc_upd = 1'b1;
        end
        lc3ie_pkg::OP_BR: begin
          if ((ins_q[11:9] & cc) != 3'b000) begin
            res_pc = pc_q + lc3ie_pkg::sext9(ins_q[8:0]);
          end
        end
        lc3ie_pkg::OP_JMP: begin
          res_pc = opa;
        end
        lc3ie_pkg::OP_JSR: begin
          if (ins_q[11]) begin
            res_pc = pc_q + lc3ie_pkg::sext11(ins_q[10:0]);
          end else begin
            res_pc = opa;
          end
          res_wr  = 1'b1;
          res_idx = lc3ie_pkg::LINK_REG;
          res_val = pc_q;
        end
        lc3ie_pkg::OP_LD: begin
          res_wr     = 1'b1;
          res_idx    = ins_q[11:9];
          res_val    = mem_rdata;
          res_cc_upd = 1'b1;
        end
        lc3ie_pkg::OP_LDI: begin
          res_ldi = 1'b1;
        end
        default: begin
          res_unsup = 1'b1;
        end
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    fin        = 1'b0;
    unique case (state)
      lc3ie_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = lc3ie_pkg::ST_EXEC;
        end
      end
      lc3ie_pkg::ST_EXEC: begin
        if (res_ldi) begin
          state_next = lc3ie_pkg::ST_LDI;
        end else begin
          fin        = 1'b1;
          state_next = lc3ie_pkg::ST_IDLE;
        end
      end
      lc3ie_pkg::ST_LDI: begin
        fin        = 1'b1;
        state_next = lc3ie_pkg::ST_IDLE;
      end
      default: begin
        state_next = lc3ie_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lc3ie_pkg::ST_IDLE;
      done     <= 1'b0;
      rf_valid <= '0;
      cc       <= lc3ie_pkg::CC_ZERO;
    end else begin
      state <= state_next;
      done  <= fin;
      if (fin && res_wr) begin
        rf_valid[res_idx] <= 1'b1;
      end
      if (fin && res_cc_upd) begin
        cc <= lc3ie_pkg::flags_of(res_val);
      end
    end
  end

  // beat capture and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      opcode_q <= opcode;
      ins_q    <= instruction;
      pc_q     <= pc;
      va_q     <= rf_valid[rfa_raddr];
      vb_q     <= rf_valid[rfb_raddr];
    end
    if (fin) begin
      next_pc     <= res_pc;
      reg_written <= res_wr;
      reg_index   <= res_idx;
      reg_value   <= res_val;
      unsupported <= res_unsup;
    end
  end

  assign cond_code = cc;

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without preceding work");

  a_cc_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(cc))
    else $error("condition code not one-hot");

  a_unsup_no_write: assert property (@(posedge clk) disable iff (rst)
    done && unsupported |-> !reg_written)
    else $error("unsupported opcode wrote a register");

  a_ldi_from_exec: assert property (@(posedge clk) disable iff (rst)
    state == lc3ie_pkg::ST_LDI |-> $past(state) == lc3ie_pkg::ST_EXEC)
    else $error("second indirect read not preceded by execute");

endmodule

### sim/testbench.sv
// self-checking testbench for the lc3 execute unit, directed rows then random items
`timescale 1ns / 1ps
module testbench;

  // opcodes the unit leaves alone
  localparam logic [3:0] OP_ST       = 4'h3;
  localparam logic [3:0] OP_LDR      = 4'h6;
  localparam logic [3:0] OP_STR      = 4'h7;
  localparam logic [3:0] OP_RTI      = 4'h8;
  localparam logic [3:0] OP_STI      = 4'hB;
  localparam logic [3:0] OP_RESERVED = 4'hD;
  localparam logic [3:0] OP_LEA      = 4'hE;
  localparam logic [3:0] OP_TRAP     = 4'hF;
  localparam logic [3:0] OTHER_OPS [8] = '{OP_ST, OP_LDR, OP_STR, OP_RTI,
                                           OP_STI, OP_RESERVED, OP_LEA, OP_TRAP};

  localparam logic [15:0] ADDR_MASK    = 16'(lc3ie_pkg::MEM_DEPTH - 1);
  localparam int          RANDOM_ITEMS = 1650;
  localparam int          RUN_LIMIT_NS = 2_000_000;

  typedef struct packed {
    logic        opcode;
    logic [15:0] instruction;
    logic [15:0] pc;
    logic [15:0] mem_addr;
    logic [15:0] mem_data;
  } item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic [2:0]  cond_code;
    logic        unsupported;
  } result_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        opcode = lc3ie_pkg::ITEM_EXEC;
  logic [15:0] instruction = 16'h0000;
  logic [15:0] pc = 16'h0000;
  logic [15:0] mem_addr = 16'h0000;
  logic [15:0] mem_data = 16'h0000;
  logic        busy;
  logic        done;
  logic [15:0] next_pc;
  logic        reg_written;
  logic [2:0]  reg_index;
  logic [15:0] reg_value;
  logic [2:0]  cond_code;
  logic        unsupported;

  // shadow architectural state
  logic [15:0] gpr [lc3ie_pkg::REG_COUNT];
  logic [2:0]  ccode;
  logic [15:0] mem_word [int];
  logic [15:0] written_addrs [$];

  result_t     expected_results [$];
  stim_row_t   directed [$];
  int          failures = 0;
  int          burst_left = 0;

  lc3_instruction_execute i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .instruction (instruction),
    .pc          (pc),
    .mem_addr    (mem_addr),
    .mem_data    (mem_data),
    .done        (done),
    .next_pc     (next_pc),
    .reg_written (reg_written),
    .reg_index   (reg_index),
    .reg_value   (reg_value),
    .cond_code   (cond_code),
    .unsupported (unsupported)
  );

  always #2 clk = ~clk;

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v == 16'h0000) return lc3ie_pkg::CC_ZERO;
    if (v[15]) return lc3ie_pkg::CC_NEG;
    return lc3ie_pkg::CC_POS;
  endfunction

  // executes one beat on the shadow state and returns the result it gives
  function automatic result_t execute_item(input item_t it);
    result_t     r;
    logic [15:0] ins;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] off9;
    logic [15:0] off11;
    r = NO_RESULT;
    ins = it.instruction;
    r.next_pc = it.pc;
    a = gpr[ins[8:6]];
    b = ins[5] ? {{11{ins[4]}}, ins[4:0]} : gpr[ins[2:0]];
    off9 = {{7{ins[8]}}, ins[8:0]};
    off11 = {{5{ins[10]}}, ins[10:0]};
    if (it.opcode == lc3ie_pkg::ITEM_MEM_LOAD) begin
      if (!mem_word.exists(it.mem_addr & ADDR_MASK)) written_addrs.push_back(it.mem_addr);
      mem_word[it.mem_addr & ADDR_MASK] = it.mem_data;
    end else begin
      case (ins[15:12])
        lc3ie_pkg::OP_ADD: begin
          r.reg_written = 1'b1;
          r.reg_index = ins[11:9];
          r.reg_value = a + b;
        end
        lc3ie_pkg::OP_AND: begin
          r.reg_written = 1'b1;
          r.reg_index = ins[11:9];
          r.reg_value = a & b;
        end
        lc3ie_pkg::OP_NOT: begin
          r.reg_written = 1'b1;
          r.reg_index = ins[11:9];
          r.reg_value = ~a;
        end
        lc3ie_pkg::OP_BR: begin
          if ((ins[11:9] & ccode) != 3'b000) r.next_pc = it.pc + off9;
        end
        lc3ie_pkg::OP_JMP: r.next_pc = a;
        lc3ie_pkg::OP_JSR: begin
          // base register is read before the link register is written
          r.next_pc = ins[11] ? it.pc + off11 : a;
          r.reg_written = 1'b1;
          r.reg_index = lc3ie_pkg::LINK_REG;
          r.reg_value = it.pc;
        end
        lc3ie_pkg::OP_LD: begin
          r.reg_written = 1'b1;
          r.reg_index = ins[11:9];
          r.reg_value = mem_word[(it.pc + off9) & ADDR_MASK];
        end
        lc3ie_pkg::OP_LDI: begin
          r.reg_written = 1'b1;
          r.reg_index = ins[11:9];
          r.reg_value = mem_word[mem_word[(it.pc + off9) & ADDR_MASK] & ADDR_MASK];
        end
        default: r.unsupported = 1'b1;
      endcase
      if (r.reg_written) begin
        gpr[r.reg_index] = r.reg_value;
        // the return address leaves the flags alone
        if (ins[15:12] != lc3ie_pkg::OP_JSR) ccode = cc_of(r.reg_value);
      end
    end
    r.cond_code = ccode;
    return r;
  endfunction

  function automatic item_t exec_item(input logic [15:0] ins, input logic [15:0] at_pc);
    item_t it;
    it.opcode = lc3ie_pkg::ITEM_EXEC;
    it.instruction = ins;
    it.pc = at_pc;
    it.mem_addr = 16'($urandom);
    it.mem_data = 16'($urandom);
    return it;
  endfunction

  function automatic item_t load_item(input logic [15:0] addr, input logic [15:0] data);
    item_t it;
    it.opcode = lc3ie_pkg::ITEM_MEM_LOAD;
    it.instruction = 16'($urandom);
    it.pc = 16'($urandom);
    it.mem_addr = addr;
    it.mem_data = data;
    return it;
  endfunction

  // drives one beat, waits for the unit to take it, then idles in bursts
  task automatic send_item(input item_t it, input logic typed, input result_t given);
    result_t predicted;
    opcode <= it.opcode;
    instruction <= it.instruction;
    pc <= it.pc;
    mem_addr <= it.mem_addr;
    mem_data <= it.mem_data;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = execute_item(it);
    expected_results.push_back(typed ? given : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // random beat; loads only ever read words that were written before
  task automatic send_random_item();
    item_t       it;
    int          pick;
    logic [15:0] ptr;
    logic [15:0] target;
    logic [15:0] off9;
    it = exec_item(16'($urandom), 16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 12) it = load_item(16'($urandom), 16'($urandom));
    else if (pick < 22) it.instruction[15:12] = lc3ie_pkg::OP_ADD;
    else if (pick < 30) it.instruction[15:12] = lc3ie_pkg::OP_AND;
    else if (pick < 36) it.instruction[15:12] = lc3ie_pkg::OP_NOT;
    else if (pick < 46) it.instruction[15:12] = lc3ie_pkg::OP_BR;
    else if (pick < 51) it.instruction[15:12] = lc3ie_pkg::OP_JMP;
    else if (pick < 58) it.instruction[15:12] = lc3ie_pkg::OP_JSR;
    else if (pick < 70) it.instruction[15:12] = lc3ie_pkg::OP_LD;
    else if (pick < 80) it.instruction[15:12] = lc3ie_pkg::OP_LDI;
    else if (pick < 90) it.instruction[15:12] = OTHER_OPS[$urandom_range(0, 7)];
    if (it.opcode == lc3ie_pkg::ITEM_EXEC &&
        (it.instruction[15:12] == lc3ie_pkg::OP_LD ||
         it.instruction[15:12] == lc3ie_pkg::OP_LDI)) begin
      if (written_addrs.size() == 0) begin
        it = load_item(16'($urandom), 16'($urandom));
      end else begin
        ptr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
        // an indirect load needs a pointer to a written word
        if (it.instruction[15:12] == lc3ie_pkg::OP_LDI &&
            !mem_word.exists(mem_word[ptr] & ADDR_MASK)) begin
          target = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
          send_item(load_item(ptr, target), 1'b0, NO_RESULT);
        end
        off9 = {{7{it.instruction[8]}}, it.instruction[8:0]};
        it.pc = ptr - off9;
      end
    end
    send_item(it, 1'b0, NO_RESULT);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // result beats against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing pending");
        failures++;
      end else begin
        want = expected_results.pop_front();
        check_field("next_pc", want.next_pc, next_pc);
        check_field("reg_written", 16'(want.reg_written), 16'(reg_written));
        check_field("reg_index", 16'(want.reg_index), 16'(reg_index));
        check_field("reg_value", want.reg_value, reg_value);
        check_field("cond_code", 16'(want.cond_code), 16'(cond_code));
        check_field("unsupported", 16'(want.unsupported), 16'(unsupported));
      end
    end
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    foreach (gpr[i]) gpr[i] = 16'h0000;
    ccode = lc3ie_pkg::CC_ZERO;
    burst_left = $urandom_range(0, 40);

    // branch, arithmetic and jump extremes
    directed.push_back('{exec_item({lc3ie_pkg::OP_BR, 3'b000, 9'h000}, 16'h1234), 1'b1,
                         '{16'h1234, 1'b0, 3'd0, 16'h0000, lc3ie_pkg::CC_ZERO, 1'b0}});
    directed.push_back('{exec_item({lc3ie_pkg::OP_BR, 3'b010, 9'h1FF}, 16'h0000), 1'b1,
                         '{16'hFFFF, 1'b0, 3'd0, 16'h0000, lc3ie_pkg::CC_ZERO, 1'b0}});
    directed.push_back('{exec_item({lc3ie_pkg::OP_ADD, 3'd1, 3'd0, 1'b1, 5'h10}, 16'h3000),
                         1'b1,
                         '{16'h3000, 1'b1, 3'd1, 16'hFFF0, lc3ie_pkg::CC_NEG, 1'b0}});
    directed.push_back('{exec_item({lc3ie_pkg::OP_ADD, 3'd2, 3'd0, 1'b1, 5'h0F}, 16'h3001),
                         1'b1,
                         '{16'h3001, 1'b1, 3'd2, 16'h000F, lc3ie_pkg::CC_POS, 1'b0}});
    directed.push_back('{exec_item({lc3ie_pkg::OP_ADD, 3'd3, 3'd1, 1'b0, 2'b11, 3'd2},
                                   16'h3002), 1'b0, NO_RESULT});
    directed.push_back('{exec_item({lc3ie_pkg::OP_AND, 3'd4, 3'd3, 1'b1, 5'h00}, 16'h3003),
                         1'b1,
                         '{16'h3003, 1'b1, 3'd4, 16'h0000, lc3ie_pkg::CC_ZERO, 1'b0}});
    directed.push_back('{exec_item({lc3ie_pkg::OP_AND, 3'd5, 3'd3, 1'b0, 2'b01, 3'd1},
                                   16'h3004), 1'b0, NO_RESULT});
    directed.push_back('{exec_item({lc3ie_pkg::OP_NOT, 3'd6, 3'd4, 6'h3F}, 16'h3005),
                         1'b0, NO_RESULT});
    directed.push_back('{exec_item({lc3ie_pkg::OP_NOT, 3'd0, 3'd6, 6'h3F}, 16'h3006),
                         1'b0, NO_RESULT});
    directed.push_back('{exec_item({lc3ie_pkg::OP_BR, 3'b100, 9'h0FF}, 16'h2000),
                         1'b0, NO_RESULT});
    directed.push_back('{exec_item({lc3ie_pkg::OP_BR, 3'b111, 9'h0FF}, 16'hFFF0),
                         1'b0, NO_RESULT});
    directed.push_back('{exec_item({lc3ie_pkg::OP_JMP, 3'b000, 3'd6, 6'h00}, 16'h3007),
                         1'b0, NO_RESULT});
    directed.push_back('{exec_item({lc3ie_pkg::OP_JSR, 1'b1, 11'h3FF}, 16'h3000),
                         1'b0, NO_RESULT});
    directed.push_back('{exec_item({lc3ie_pkg::OP_JSR, 1'b1, 11'h400}, 16'h0100),
                         1'b0, NO_RESULT});
    directed.push_back('{exec_item({lc3ie_pkg::OP_JSR, 1'b0, 2'b00, 3'd7, 6'h00}, 16'h5000),
                         1'b0, NO_RESULT});
    // memory fill, then direct and indirect loads with wrapping addresses
    directed.push_back('{load_item(16'h0000, 16'h8000), 1'b0, NO_RESULT});
    directed.push_back('{load_item(16'hFFFF, 16'h0000), 1'b0, NO_RESULT});
    directed.push_back('{load_item(16'h1234, 16'h0000), 1'b0, NO_RESULT});
    directed.push_back('{load_item(16'h7FFF, 16'hFFFF), 1'b0, NO_RESULT});
    directed.push_back('{exec_item({lc3ie_pkg::OP_LD, 3'd1, 9'h1FF}, 16'h0001),
                         1'b0, NO_RESULT});
    directed.push_back('{exec_item({lc3ie_pkg::OP_LD, 3'd2, 9'h1FF}, 16'h0000),
                         1'b0, NO_RESULT});
    directed.push_back('{exec_item({lc3ie_pkg::OP_LDI, 3'd3, 9'h000}, 16'h1234),
                         1'b0, NO_RESULT});
    directed.push_back('{exec_item({lc3ie_pkg::OP_LDI, 3'd5, 9'h100}, 16'h80FF),
                         1'b0, NO_RESULT});
    // opcodes outside the executed set
    directed.push_back('{exec_item({OP_ST, 12'hFFF}, 16'h4444), 1'b0, NO_RESULT});
    directed.push_back('{exec_item({OP_RESERVED, 12'h000}, 16'hFFFF), 1'b0, NO_RESULT});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i].it, directed[i].typed, directed[i].want);
    repeat (RANDOM_ITEMS) send_random_item();

    // drain outstanding results
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
rtl/lc3ie_pkg.sv
rtl/lc3ie_ram.sv
rtl/lc3_instruction_execute.sv
sim/testbench.sv
